@@ hw/rtl/easter_feast_date_calculator_unit_assert.svh @@
// assertion helpers for the bound checker efdc_checker
`ifndef EASTER_FEAST_DATE_CALCULATOR_UNIT_ASSERT_SVH
`define EASTER_FEAST_DATE_CALCULATOR_UNIT_ASSERT_SVH

// condition must hold on every clock edge outside reset
`define EFDC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("efdc check failed: invariant");

// antecedent implies consequent (consequent may be a delayed sequence)
`define EFDC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("efdc check failed: implication");

`endif

@@ hw/rtl/efdc_pkg.sv @@
package efdc_pkg;

   // number of register stages from accepted request to result strobe
   localparam int PIPE_DEPTH = 8;

   // accepted year range
   localparam int YEAR_MIN = 1583;
   localparam int YEAR_MAX = 9999;

   // reciprocal multipliers for the constant divisions (value = floor(x * R >> S))
   localparam int RECIP_19  = 27595;
   localparam int SHIFT_19  = 19;
   localparam int RECIP_100 = 5243;
   localparam int SHIFT_100 = 19;
   localparam int RECIP_25  = 41;
   localparam int SHIFT_25  = 10;
   localparam int RECIP_3   = 171;
   localparam int SHIFT_3   = 9;
   localparam int RECIP_30  = 547;
   localparam int SHIFT_30  = 14;
   localparam int RECIP_7   = 147;
   localparam int SHIFT_7   = 10;

   // threshold of the m term of the computus
   localparam int M_LIMIT = 451;

   // feast offsets relative to easter sunday, in days
   localparam logic signed [7:0] OFS_CARNIVAL  = -8'sd49;
   localparam logic signed [7:0] OFS_FRIDAY    = -8'sd2;
   localparam logic signed [7:0] OFS_ASCENSION = 8'sd39;
   localparam logic signed [7:0] OFS_PENTECOST = 8'sd49;

   // first day of each month as an offset from 1 march
   localparam logic signed [7:0] START_APR = 8'sd31;
   localparam logic signed [7:0] START_MAY = 8'sd61;
   localparam logic signed [7:0] START_JUN = 8'sd92;

   // month codes
   localparam logic [2:0] MON_FEB = 3'd2;
   localparam logic [2:0] MON_MAR = 3'd3;
   localparam logic [2:0] MON_APR = 3'd4;
   localparam logic [2:0] MON_MAY = 3'd5;
   localparam logic [2:0] MON_JUN = 3'd6;

   typedef struct packed {
      logic [4:0] dom;
      logic [2:0] mon;
   } date_type;

endpackage

@@ hw/rtl/efdc_date_conv.sv @@
module efdc_date_conv
   import efdc_pkg::*;
(
   input  logic signed [7:0] offset,
   input  logic              leap,
   output date_type          date
);

   logic signed [7:0] feb_dom;
   logic signed [7:0] mon_dom;

   // day within february when the offset falls before 1 march
   assign feb_dom = (leap ? 8'sd29 : 8'sd28) + offset + 8'sd1;

   // pick the month by comparing against month starts
   always_comb begin
      mon_dom = offset + 8'sd1;
      date.mon = MON_MAR;
      if (offset < 8'sd0) begin
         mon_dom = (feb_dom < 8'sd1) ? 8'sd1 : feb_dom;
         date.mon = MON_FEB;
      end else if (offset >= START_JUN) begin
         mon_dom = offset - START_JUN + 8'sd1;
         date.mon = MON_JUN;
      end else if (offset >= START_MAY) begin
         mon_dom = offset - START_MAY + 8'sd1;
         date.mon = MON_MAY;
      end else if (offset >= START_APR) begin
         mon_dom = offset - START_APR + 8'sd1;
         date.mon = MON_APR;
      end
      date.dom = mon_dom[4:0];
   end

endmodule

@@ hw/rtl/easter_feast_date_calculator_unit.sv @@
// Gregorian Easter and dependent feast dates. A year is taken on every cycle in which
// start is high (busy is always low), and its five dates appear on the rsp_ ports
// for one cycle, marked by rsp_strobe. The pipeline stages follow the chain of
// constant divisions of the computus (by 19 and 100, by 25, by 3, modulo 30,
// modulo 7), each done by reciprocal multiplication in a stage of its own, plus one
// stage that finishes the sum ahead of the modulo 30, one for the 451 threshold and
// one that turns day offsets into day and month. The receiver cannot stall: every
// strobe must be captured in its cycle. For years outside 1583..9999, rsp_year_in_range
// is low and all date fields read zero.
module easter_feast_date_calculator_unit
   import efdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [13:0] req_calendar_year,
   output logic        rsp_strobe,
   output logic        rsp_year_in_range,
   output logic [4:0]  rsp_easter_dom,
   output logic [2:0]  rsp_easter_mon,
   output logic [4:0]  rsp_carnival_dom,
   output logic [1:0]  rsp_carnival_mon,
   output logic [4:0]  rsp_friday_dom,
   output logic [2:0]  rsp_friday_mon,
   output logic [4:0]  rsp_ascension_dom,
   output logic [2:0]  rsp_ascension_mon,
   output logic [4:0]  rsp_pentecost_dom,
   output logic [2:0]  rsp_pentecost_mon
);

   // valid bits, one per stage
   logic [PIPE_DEPTH-1:0] vld_ff, vld_in;
   // range and leap flags travel with stages 1..7
   logic [PIPE_DEPTH-2:0] inr_ff, inr_in;
   logic [PIPE_DEPTH-2:0] leap_ff, leap_in;

   logic        inr_s1;
   logic        leap_s1;

   // stage 1: year mod 19, year / 100, year mod 100
   logic [28:0] prod19, prod100;
   logic [9:0]  q19;
   logic [7:0]  q100;
   logic [13:0] rem19, rem100;
   logic [4:0]  s1_a_ff, s1_a_in;
   logic [7:0]  s1_b_ff, s1_b_in;
   logic [6:0]  s1_c_ff, s1_c_in;

   // stage 2: d, e, f, i, k
   logic [8:0]  bsum;
   logic [14:0] prod25;
   logic [4:0]  s2_a_ff;
   logic [7:0]  s2_b_ff;
   logic [5:0]  s2_d_ff, s2_d_in;
   logic [1:0]  s2_e_ff, s2_e_in;
   logic [4:0]  s2_f_ff, s2_f_in;
   logic [4:0]  s2_i_ff, s2_i_in;
   logic [1:0]  s2_k_ff, s2_k_in;

   // stage 3: g, partial h sum, partial l sum
   logic [8:0]  gnum;
   logic [16:0] prod3;
   logic [4:0]  s3_a_ff;
   logic [6:0]  s3_g_ff, s3_g_in;
   logic [9:0]  s3_p_ff, s3_p_in;
   logic [6:0]  s3_t_ff, s3_t_in;

   // stage 4: full h sum
   logic [4:0]  s4_a_ff;
   logic [9:0]  s4_s_ff, s4_s_in;
   logic [6:0]  s4_t_ff;

   // stage 5: h = sum mod 30
   logic [19:0] prod30;
   logic [4:0]  q30;
   logic [9:0]  hfull;
   logic [4:0]  s5_a_ff;
   logic [4:0]  s5_h_ff, s5_h_in;
   logic [6:0]  s5_t_ff;

   // stage 6: l = (32 + 2e + 2i - h - k) mod 7, a + 11h
   logic [6:0]  lsum;
   logic [14:0] prod7;
   logic [4:0]  q7;
   logic [6:0]  lfull;
   logic [4:0]  s6_h_ff;
   logic [2:0]  s6_l_ff, s6_l_in;
   logic [8:0]  s6_v_ff, s6_v_in;

   // stage 7: m and easter offset from 1 march
   logic [9:0]  msum;
   logic        mflag;
   logic [5:0]  s7_off_ff, s7_off_in;

   // stage 8: conversions to day and month
   logic signed [7:0] off_s;
   date_type    easter_date, carnival_date, friday_date, ascension_date, pentecost_date;
   logic        rsp_inr_ff;
   date_type    rsp_easter_ff, rsp_easter_in;
   date_type    rsp_carnival_ff, rsp_carnival_in;
   date_type    rsp_friday_ff, rsp_friday_in;
   date_type    rsp_ascension_ff, rsp_ascension_in;
   date_type    rsp_pentecost_ff, rsp_pentecost_in;

   // the pipeline never stalls
   assign busy = 1'b0;

   // valid and flag shift lines
   always_comb begin
      vld_in  = {vld_ff[PIPE_DEPTH-2:0], start && !busy};
      inr_in  = {inr_ff[PIPE_DEPTH-3:0], inr_s1};
      leap_in = {leap_ff[PIPE_DEPTH-3:0], leap_s1};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      inr_ff  <= inr_in;
      leap_ff <= leap_in;
   end

   // stage 1 logic
   always_comb begin
      prod19  = 29'(req_calendar_year) * 29'(RECIP_19);
      q19     = prod19[SHIFT_19 +: 10];
      rem19   = req_calendar_year - 14'(14'(q19) * 14'd19);
      prod100 = 29'(req_calendar_year) * 29'(RECIP_100);
      q100    = prod100[SHIFT_100 +: 8];
      rem100  = req_calendar_year - 14'(14'(q100) * 14'd100);
      s1_a_in = rem19[4:0];
      s1_b_in = q100;
      s1_c_in = rem100[6:0];
      inr_s1  = (req_calendar_year >= 14'(YEAR_MIN)) && (req_calendar_year <= 14'(YEAR_MAX));
      leap_s1 = ((req_calendar_year[1:0] == 2'd0) && (s1_c_in != 7'd0))
             || ((s1_c_in == 7'd0) && (q100[1:0] == 2'd0));
   end

   // stage 2 logic
   always_comb begin
      bsum    = 9'(s1_b_ff) + 9'd8;
      prod25  = 15'(bsum) * 15'(RECIP_25);
      s2_f_in = prod25[SHIFT_25 +: 5];
      s2_d_in = s1_b_ff[7:2];
      s2_e_in = s1_b_ff[1:0];
      s2_i_in = s1_c_ff[6:2];
      s2_k_in = s1_c_ff[1:0];
   end

   // stage 3 logic
   always_comb begin
      gnum    = 9'(s2_b_ff) - 9'(s2_f_ff) + 9'd1;
      prod3   = 17'(gnum) * 17'(RECIP_3);
      s3_g_in = prod3[SHIFT_3 +: 7];
      s3_p_in = 10'(s2_a_ff) * 10'd19 + 10'(s2_b_ff) - 10'(s2_d_ff) + 10'd15;
      s3_t_in = 7'd32 + 7'({s2_e_ff, 1'b0}) + 7'({s2_i_ff, 1'b0}) - 7'(s2_k_ff);
   end

   // stage 4 logic
   assign s4_s_in = s3_p_ff - 10'(s3_g_ff);

   // stage 5 logic
   always_comb begin
      prod30  = 20'(s4_s_ff) * 20'(RECIP_30);
      q30     = prod30[SHIFT_30 +: 5];
      hfull   = s4_s_ff - 10'(10'(q30) * 10'd30);
      s5_h_in = hfull[4:0];
   end

   // stage 6 logic
   always_comb begin
      lsum    = s5_t_ff - 7'(s5_h_ff);
      prod7   = 15'(lsum) * 15'(RECIP_7);
      q7      = prod7[SHIFT_7 +: 5];
      lfull   = lsum - 7'(7'(q7) * 7'd7);
      s6_l_in = lfull[2:0];
      s6_v_in = 9'(s5_a_ff) + 9'(s5_h_ff) * 9'd11;
   end

   // stage 7 logic
   always_comb begin
      msum      = 10'(s6_v_ff) + 10'(s6_l_ff) * 10'd22;
      mflag     = (msum >= 10'(M_LIMIT));
      s7_off_in = 6'(s6_h_ff) + 6'(s6_l_ff) - (mflag ? 6'd7 : 6'd0) + 6'd21;
   end

   // stage registers
   always_ff @(posedge clock) begin
      s1_a_ff   <= s1_a_in;
      s1_b_ff   <= s1_b_in;
      s1_c_ff   <= s1_c_in;
      s2_a_ff   <= s1_a_ff;
      s2_b_ff   <= s1_b_ff;
      s2_d_ff   <= s2_d_in;
      s2_e_ff   <= s2_e_in;
      s2_f_ff   <= s2_f_in;
      s2_i_ff   <= s2_i_in;
      s2_k_ff   <= s2_k_in;
      s3_a_ff   <= s2_a_ff;
      s3_g_ff   <= s3_g_in;
      s3_p_ff   <= s3_p_in;
      s3_t_ff   <= s3_t_in;
      s4_a_ff   <= s3_a_ff;
      s4_s_ff   <= s4_s_in;
      s4_t_ff   <= s3_t_ff;
      s5_a_ff   <= s4_a_ff;
      s5_h_ff   <= s5_h_in;
      s5_t_ff   <= s4_t_ff;
      s6_h_ff   <= s5_h_ff;
      s6_l_ff   <= s6_l_in;
      s6_v_ff   <= s6_v_in;
      s7_off_ff <= s7_off_in;
   end

   // stage 8: one converter per feast
   assign off_s = signed'({2'b00, s7_off_ff});

   efdc_date_conv u_conv_easter (
      .offset (off_s),
      .leap   (leap_ff[PIPE_DEPTH-2]),
      .date   (easter_date)
   );

   efdc_date_conv u_conv_carnival (
      .offset (off_s + OFS_CARNIVAL),
      .leap   (leap_ff[PIPE_DEPTH-2]),
      .date   (carnival_date)
   );

   efdc_date_conv u_conv_friday (
      .offset (off_s + OFS_FRIDAY),
      .leap   (leap_ff[PIPE_DEPTH-2]),
      .date   (friday_date)
   );

   efdc_date_conv u_conv_ascension (
      .offset (off_s + OFS_ASCENSION),
      .leap   (leap_ff[PIPE_DEPTH-2]),
      .date   (ascension_date)
   );

   efdc_date_conv u_conv_pentecost (
      .offset (off_s + OFS_PENTECOST),
      .leap   (leap_ff[PIPE_DEPTH-2]),
      .date   (pentecost_date)
   );

   // zero the dates of an out-of-range year
   always_comb begin
      rsp_easter_in    = inr_ff[PIPE_DEPTH-2] ? easter_date : '0;
      rsp_carnival_in  = inr_ff[PIPE_DEPTH-2] ? carnival_date : '0;
      rsp_friday_in    = inr_ff[PIPE_DEPTH-2] ? friday_date : '0;
      rsp_ascension_in = inr_ff[PIPE_DEPTH-2] ? ascension_date : '0;
      rsp_pentecost_in = inr_ff[PIPE_DEPTH-2] ? pentecost_date : '0;
   end

   always_ff @(posedge clock) begin
      rsp_inr_ff       <= inr_ff[PIPE_DEPTH-2];
      rsp_easter_ff    <= rsp_easter_in;
      rsp_carnival_ff  <= rsp_carnival_in;
      rsp_friday_ff    <= rsp_friday_in;
      rsp_ascension_ff <= rsp_ascension_in;
      rsp_pentecost_ff <= rsp_pentecost_in;
   end

   // result transfer
   assign rsp_strobe        = vld_ff[PIPE_DEPTH-1];
   assign rsp_year_in_range = rsp_inr_ff;
   assign rsp_easter_dom    = rsp_easter_ff.dom;
   assign rsp_easter_mon    = rsp_easter_ff.mon;
   assign rsp_carnival_dom  = rsp_carnival_ff.dom;
   assign rsp_carnival_mon  = rsp_carnival_ff.mon[1:0];
   assign rsp_friday_dom    = rsp_friday_ff.dom;
   assign rsp_friday_mon    = rsp_friday_ff.mon;
   assign rsp_ascension_dom = rsp_ascension_ff.dom;
   assign rsp_ascension_mon = rsp_ascension_ff.mon;
   assign rsp_pentecost_dom = rsp_pentecost_ff.dom;
   assign rsp_pentecost_mon = rsp_pentecost_ff.mon;

endmodule

@@ hw/rtl/efdc_checker.sv @@
module efdc_checker
   import efdc_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_year_in_range,
   input logic [4:0]  rsp_easter_dom,
   input logic [2:0]  rsp_easter_mon,
   input logic [4:0]  rsp_carnival_dom,
   input logic [1:0]  rsp_carnival_mon,
   input logic [4:0]  rsp_friday_dom,
   input logic [2:0]  rsp_friday_mon,
   input logic [4:0]  rsp_ascension_dom,
   input logic [2:0]  rsp_ascension_mon,
   input logic [4:0]  rsp_pentecost_dom,
   input logic [2:0]  rsp_pentecost_mon
);

`include "easter_feast_date_calculator_unit_assert.svh"

   logic req_xfer;
   logic dates_zero;
   logic months_ok;

   assign req_xfer   = start && !busy;
   assign dates_zero = (rsp_easter_dom == 5'd0) && (rsp_easter_mon == 3'd0)
                    && (rsp_carnival_dom == 5'd0) && (rsp_carnival_mon == 2'd0)
                    && (rsp_friday_dom == 5'd0) && (rsp_friday_mon == 3'd0)
                    && (rsp_ascension_dom == 5'd0) && (rsp_ascension_mon == 3'd0)
                    && (rsp_pentecost_dom == 5'd0) && (rsp_pentecost_mon == 3'd0);
   assign months_ok  = ((rsp_easter_mon == MON_MAR) || (rsp_easter_mon == MON_APR))
                    && ((rsp_pentecost_mon == MON_MAY) || (rsp_pentecost_mon == MON_JUN));

   // the pipeline takes a request on every cycle
   `EFDC_ASSERT_ALWAYS(a_never_busy, clock, reset, !busy)

   // every request transfer is followed by a result strobe
   `EFDC_ASSERT_IMPLY(a_rsp_follows, clock, reset, req_xfer, ##PIPE_DEPTH rsp_strobe)

   // no result without an earlier request transfer
   `EFDC_ASSERT_IMPLY(a_rsp_origin, clock, reset, rsp_strobe, $past(req_xfer, PIPE_DEPTH))

   // out-of-range years carry all-zero dates
   `EFDC_ASSERT_IMPLY(a_zero_dates, clock, reset, rsp_strobe && !rsp_year_in_range, dates_zero)

   // in-range easter falls in march or april and pentecost in may or june
   `EFDC_ASSERT_IMPLY(a_month_window, clock, reset, rsp_strobe && rsp_year_in_range, months_ok)

endmodule

bind easter_feast_date_calculator_unit efdc_checker u_efdc_checker (.*);

@@ sim/easter_feast_date_calculator_unit_checker.sv @@
module easter_feast_date_calculator_unit_checker
   import efdc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        busy,
   input  logic [13:0] req_calendar_year,
   input  logic        rsp_strobe,
   input  logic        rsp_year_in_range,
   input  logic [4:0]  rsp_easter_dom,
   input  logic [2:0]  rsp_easter_mon,
   input  logic [4:0]  rsp_carnival_dom,
   input  logic [1:0]  rsp_carnival_mon,
   input  logic [4:0]  rsp_friday_dom,
   input  logic [2:0]  rsp_friday_mon,
   input  logic [4:0]  rsp_ascension_dom,
   input  logic [2:0]  rsp_ascension_mon,
   input  logic [4:0]  rsp_pentecost_dom,
   input  logic [2:0]  rsp_pentecost_mon,
   output int          mismatch_count,
   output int          pending_results,
   output int          results_checked,
   output int          carnival_feb_end_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic       in_range;
      logic [4:0] easter_dom;
      logic [2:0] easter_mon;
      logic [4:0] carnival_dom;
      logic [1:0] carnival_mon;
      logic [4:0] friday_dom;
      logic [2:0] friday_mon;
      logic [4:0] ascension_dom;
      logic [2:0] ascension_mon;
      logic [4:0] pentecost_dom;
      logic [2:0] pentecost_mon;
   } feast_dates_t;

   feast_dates_t expected_dates[$];

   function automatic bit gregorian_leap(input int yr);
      return ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
   endfunction

   // meeus/jones/butcher computus, easter as day offset from 1 march
   function automatic int easter_day_offset(input int yr);
      int golden, century, yr_in_cent, cent_q4, cent_r4, corr_f, corr_g;
      int epact, yr_q4, yr_r4, wk_day, m_term, base_day, month_num, day_num;
      golden     = yr % 19;
      century    = yr / 100;
      yr_in_cent = yr % 100;
      cent_q4    = century / 4;
      cent_r4    = century % 4;
      corr_f     = (century + 8) / 25;
      corr_g     = (century - corr_f + 1) / 3;
      epact      = (19 * golden + century - cent_q4 - corr_g + 15) % 30;
      yr_q4      = yr_in_cent / 4;
      yr_r4      = yr_in_cent % 4;
      wk_day     = (32 + 2 * cent_r4 + 2 * yr_q4 - epact - yr_r4) % 7;
      m_term     = (golden + 11 * epact + 22 * wk_day) / M_LIMIT;
      base_day   = epact + wk_day - 7 * m_term + 114;
      month_num  = base_day / 31;
      day_num    = base_day % 31 + 1;
      return (month_num == MON_MAR) ? (day_num - 1) : (31 + day_num - 1);
   endfunction

   // day offset from 1 march to day of month and month
   function automatic void offset_to_day_month(input int yr, input int ofs,
                                               output logic [4:0] dom,
                                               output logic [2:0] mon);
      int feb_len, day_val;
      if (ofs < 0) begin
         feb_len = gregorian_leap(yr) ? 29 : 28;
         day_val = feb_len + ofs + 1;
         if (day_val < 1) day_val = 1;
         dom = day_val[4:0];
         mon = MON_FEB;
      end else if (ofs < START_APR) begin
         dom = 5'(ofs + 1);
         mon = MON_MAR;
      end else if (ofs < START_MAY) begin
         dom = 5'(ofs - START_APR + 1);
         mon = MON_APR;
      end else if (ofs < START_JUN) begin
         dom = 5'(ofs - START_MAY + 1);
         mon = MON_MAY;
      end else begin
         dom = 5'(ofs - START_JUN + 1);
         mon = MON_JUN;
      end
   endfunction

   function automatic feast_dates_t compute_feast_dates(input logic [13:0] year_in);
      feast_dates_t fd;
      logic [2:0] carn_mon;
      int yr, easter_ofs;
      fd = '0;
      yr = int'(year_in);
      if (yr < YEAR_MIN || yr > YEAR_MAX) return fd;
      easter_ofs  = easter_day_offset(yr);
      fd.in_range = 1'b1;
      offset_to_day_month(yr, easter_ofs, fd.easter_dom, fd.easter_mon);
      offset_to_day_month(yr, easter_ofs + OFS_CARNIVAL, fd.carnival_dom, carn_mon);
      fd.carnival_mon = carn_mon[1:0];
      offset_to_day_month(yr, easter_ofs + OFS_FRIDAY, fd.friday_dom, fd.friday_mon);
      offset_to_day_month(yr, easter_ofs + OFS_ASCENSION, fd.ascension_dom,
                          fd.ascension_mon);
      offset_to_day_month(yr, easter_ofs + OFS_PENTECOST, fd.pentecost_dom,
                          fd.pentecost_mon);
      return fd;
   endfunction

   // one field compare, counts and reports a mismatch
   task automatic check_field(input string field_name, input int exp_val, input int act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", field_name, exp_val, act_val);
         mismatch_count++;
      end
   endtask

   // predict on request transfer, compare on result transfer
   always @(posedge clock) begin
      feast_dates_t exp_fd;
      if (reset) begin
         expected_dates.delete();
         mismatch_count         = 0;
         pending_results        = 0;
         results_checked        = 0;
         carnival_feb_end_count = 0;
      end else begin
         if (rsp_strobe) begin
            if (expected_dates.size() == 0) begin
               $error("result transfer with no expected dates pending");
               mismatch_count++;
            end else begin
               exp_fd = expected_dates.pop_front();
               check_field("year_in_range", int'(exp_fd.in_range), int'(rsp_year_in_range));
               check_field("easter_dom", int'(exp_fd.easter_dom), int'(rsp_easter_dom));
               check_field("easter_mon", int'(exp_fd.easter_mon), int'(rsp_easter_mon));
               check_field("carnival_dom", int'(exp_fd.carnival_dom),
                           int'(rsp_carnival_dom));
               check_field("carnival_mon", int'(exp_fd.carnival_mon),
                           int'(rsp_carnival_mon));
               check_field("friday_dom", int'(exp_fd.friday_dom), int'(rsp_friday_dom));
               check_field("friday_mon", int'(exp_fd.friday_mon), int'(rsp_friday_mon));
               check_field("ascension_dom", int'(exp_fd.ascension_dom),
                           int'(rsp_ascension_dom));
               check_field("ascension_mon", int'(exp_fd.ascension_mon),
                           int'(rsp_ascension_mon));
               check_field("pentecost_dom", int'(exp_fd.pentecost_dom),
                           int'(rsp_pentecost_dom));
               check_field("pentecost_mon", int'(exp_fd.pentecost_mon),
                           int'(rsp_pentecost_mon));
               results_checked++;
            end
         end
         if (start && !busy) begin
            exp_fd = compute_feast_dates(req_calendar_year);
            // carnival landing on the last day of february
            if (exp_fd.in_range && exp_fd.carnival_mon == MON_FEB[1:0] &&
                int'(exp_fd.carnival_dom) ==
                (gregorian_leap(int'(req_calendar_year)) ? 29 : 28))
               carnival_feb_end_count++;
            expected_dates.push_back(exp_fd);
         end
         pending_results = expected_dates.size();
      end
   end

endmodule

@@ sim/tb_easter_feast_date_calculator_unit.sv @@
module tb_easter_feast_date_calculator_unit
   import efdc_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NUM_RANDOM_YEARS = 850;
   localparam int CYCLE_LIMIT      = 200000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [13:0] req_calendar_year;
   logic        rsp_strobe;
   logic        rsp_year_in_range;
   logic [4:0]  rsp_easter_dom;
   logic [2:0]  rsp_easter_mon;
   logic [4:0]  rsp_carnival_dom;
   logic [1:0]  rsp_carnival_mon;
   logic [4:0]  rsp_friday_dom;
   logic [2:0]  rsp_friday_mon;
   logic [4:0]  rsp_ascension_dom;
   logic [2:0]  rsp_ascension_mon;
   logic [4:0]  rsp_pentecost_dom;
   logic [2:0]  rsp_pentecost_mon;

   int mismatch_count;
   int pending_results;
   int results_checked;
   int carnival_feb_end_count;
   int cycle_count = 0;
   int years_sent;
   int years_out_of_range;

   easter_feast_date_calculator_unit i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_calendar_year (req_calendar_year),
      .rsp_strobe        (rsp_strobe),
      .rsp_year_in_range (rsp_year_in_range),
      .rsp_easter_dom    (rsp_easter_dom),
      .rsp_easter_mon    (rsp_easter_mon),
      .rsp_carnival_dom  (rsp_carnival_dom),
      .rsp_carnival_mon  (rsp_carnival_mon),
      .rsp_friday_dom    (rsp_friday_dom),
      .rsp_friday_mon    (rsp_friday_mon),
      .rsp_ascension_dom (rsp_ascension_dom),
      .rsp_ascension_mon (rsp_ascension_mon),
      .rsp_pentecost_dom (rsp_pentecost_dom),
      .rsp_pentecost_mon (rsp_pentecost_mon)
   );

   easter_feast_date_calculator_unit_checker i_checker (
      .clock                  (clock),
      .reset                  (reset),
      .start                  (start),
      .busy                   (busy),
      .req_calendar_year      (req_calendar_year),
      .rsp_strobe             (rsp_strobe),
      .rsp_year_in_range      (rsp_year_in_range),
      .rsp_easter_dom         (rsp_easter_dom),
      .rsp_easter_mon         (rsp_easter_mon),
      .rsp_carnival_dom       (rsp_carnival_dom),
      .rsp_carnival_mon       (rsp_carnival_mon),
      .rsp_friday_dom         (rsp_friday_dom),
      .rsp_friday_mon         (rsp_friday_mon),
      .rsp_ascension_dom      (rsp_ascension_dom),
      .rsp_ascension_mon      (rsp_ascension_mon),
      .rsp_pentecost_dom      (rsp_pentecost_dom),
      .rsp_pentecost_mon      (rsp_pentecost_mon),
      .mismatch_count         (mismatch_count),
      .pending_results        (pending_results),
      .results_checked        (results_checked),
      .carnival_feb_end_count (carnival_feb_end_count)
   );

   // 12 ns clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // one year transfer; start stays high when the next call follows at once
   task automatic send_year(input logic [13:0] year_val);
      start             <= 1'b1;
      req_calendar_year <= year_val;
      if (int'(year_val) < YEAR_MIN || int'(year_val) > YEAR_MAX) years_out_of_range++;
      @(posedge clock);
      while (busy) @(posedge clock);
      years_sent++;
   endtask

   task automatic idle_cycles(input int n);
      start <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   // mostly valid years, some around the range edges, some anywhere
   function automatic logic [13:0] random_year();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 78) return 14'($urandom_range(YEAR_MIN, YEAR_MAX));
      if (pick < 84) return 14'($urandom_range(YEAR_MIN - 8, YEAR_MIN + 8));
      if (pick < 90) return 14'($urandom_range(YEAR_MAX - 8, YEAR_MAX + 8));
      return 14'($urandom_range(0, 16383));
   endfunction

   initial begin
      logic [13:0] directed_years[$];
      int burst_len;
      int gap_len;
      int random_sent;

      start              <= 1'b0;
      req_calendar_year  <= '0;
      reset              <= 1'b1;
      years_sent         = 0;
      years_out_of_range = 0;
      random_sent        = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // range edges, leap rules, earliest and latest easter,
      // carnival on the last day of february in common and leap years
      directed_years = '{14'd0, 14'd1582, 14'd1583, 14'd1584, 14'd9999, 14'd10000,
                         14'd16383, 14'd8191, 14'd1900, 14'd2000, 14'd2100, 14'd2400,
                         14'd1818, 14'd2285, 14'd1943, 14'd2038, 14'd1954, 14'd1976,
                         14'd2049, 14'd1981, 14'd2024, 14'd2008, 14'd4096, 14'd5461,
                         14'd2730};
      foreach (directed_years[idx]) send_year(directed_years[idx]);
      idle_cycles(3);

      // random bursts with random gaps, some stretches back to back
      while (random_sent < NUM_RANDOM_YEARS) begin
         burst_len = $urandom_range(1, 24);
         for (int n = 0; n < burst_len && random_sent < NUM_RANDOM_YEARS; n++) begin
            send_year(random_year());
            random_sent++;
         end
         gap_len = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
         if (gap_len > 0) idle_cycles(gap_len);
      end
      start <= 1'b0;

      // drain the pipeline, then keep watching for stray strobes
      while (pending_results != 0) @(posedge clock);
      repeat (2 * PIPE_DEPTH) @(posedge clock);

      $display("covered %0d years (%0d outside the valid range), %0d results checked",
               years_sent, years_out_of_range, results_checked);
      $display("carnival fell on the last day of february %0d times",
               carnival_feb_end_count);
      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
